[src/hcm_pkg.sv]
`default_nettype none

package hcm_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int ORDER_W       = 5;
  localparam int COORD_W       = 16;
  localparam int KEY_W         = 32;
  localparam int IN_COORD_W    = 32;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd8;

  typedef logic [1:0] hc_state_t;
  typedef logic [1:0] hc_digit_t;

  typedef enum logic {
    OP_KEY2PT = 1'b0,
    OP_PT2KEY = 1'b1
  } hcm_op_t;

  // Curve tables, indexed [state][digit]
  localparam hc_digit_t PT2KEY_TBL [4][4] = '{
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd2, 2'd1, 2'd3, 2'd0},
    '{2'd2, 2'd3, 2'd1, 2'd0}
  };

  localparam hc_digit_t KEY2PT_TBL [4][4] = '{
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd3, 2'd1, 2'd0, 2'd2},
    '{2'd3, 2'd2, 2'd0, 2'd1}
  };

  localparam hc_state_t NEXT_TBL [4][4] = '{
    '{2'd1, 2'd0, 2'd0, 2'd2},
    '{2'd0, 2'd1, 2'd1, 2'd3},
    '{2'd3, 2'd2, 2'd2, 2'd0},
    '{2'd2, 2'd3, 2'd3, 2'd1}
  };

  typedef struct packed {
    hcm_op_t                         op;
    logic        [KEY_W-1:0]         index_in;
    logic signed [IN_COORD_W-1:0]    x_in;
    logic signed [IN_COORD_W-1:0]    y_in;
  } hcm_req_t;

  typedef struct packed {
    logic        [KEY_W-1:0]   index_out;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      out_of_range;
  } hcm_rsp_t;

  // Word travelling down the cell row
  typedef struct packed {
    hcm_op_t              op;
    logic                 oor;
    logic [ORDER_W-1:0]   order;
    hc_state_t            st;
    logic [KEY_W-1:0]     key;
    logic [COORD_W-1:0]   ux;
    logic [COORD_W-1:0]   uy;
  } hcm_stage_t;

  function automatic logic [COORD_W-1:0] half_side(input logic [ORDER_W-1:0] order);
    return COORD_W'(1) << (order - ORDER_W'(1));
  endfunction

endpackage

`default_nettype wire

[src/hcm_prep.sv]
`default_nettype none

module hcm_prep #(
  parameter int MAX_ORDER = hcm_pkg::MAX_ORDER_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  output logic                          req_ready,
  input  hcm_pkg::hcm_req_t             req_word,
  input  wire [hcm_pkg::ORDER_W-1:0]    curve_order,
  output logic                          dn_valid,
  input  wire                           dn_ready,
  output hcm_pkg::hcm_stage_t           dn_data
);

  logic [hcm_pkg::ORDER_W-1:0]          order_eff;
  logic [hcm_pkg::COORD_W-1:0]          shift;
  logic signed [hcm_pkg::IN_COORD_W-1:0] pos_lim;
  logic signed [hcm_pkg::IN_COORD_W-1:0] neg_lim;
  hcm_pkg::hcm_stage_t                  data_next;

  always_comb begin
    order_eff = curve_order;
    if (order_eff == '0) begin
      order_eff = hcm_pkg::ORDER_W'(1);
    end
    if (order_eff > hcm_pkg::ORDER_W'(MAX_ORDER)) begin
      order_eff = hcm_pkg::ORDER_W'(MAX_ORDER);
    end
    shift   = hcm_pkg::half_side(order_eff);
    pos_lim = $signed(hcm_pkg::IN_COORD_W'(shift));
    neg_lim = -pos_lim;

    data_next       = '0;
    data_next.op    = req_word.op;
    data_next.order = order_eff;
    if (req_word.op == hcm_pkg::OP_KEY2PT) begin
      data_next.key = req_word.index_in;
    end else begin
      data_next.oor = (req_word.x_in <= neg_lim) || (req_word.x_in >= pos_lim) ||
                      (req_word.y_in <= neg_lim) || (req_word.y_in >= pos_lim);
      data_next.ux  = req_word.x_in[hcm_pkg::COORD_W-1:0] + shift;
      data_next.uy  = req_word.y_in[hcm_pkg::COORD_W-1:0] + shift;
    end
  end

  assign req_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (req_ready) begin
      dn_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[src/hcm_cell.sv]
`default_nettype none

module hcm_cell #(
  parameter int LEVEL = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  hcm_pkg::hcm_stage_t  up_data,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output hcm_pkg::hcm_stage_t  dn_data
);

  hcm_pkg::hcm_stage_t data_next;
  hcm_pkg::hc_digit_t  digit;
  hcm_pkg::hc_digit_t  co;

  // One curve level: consume the digit (or coordinate bit pair) and write
  // the converted bit pair (or digit) back at the same level.
  always_comb begin
    data_next = up_data;
    digit     = '0;
    co        = '0;
    if (up_data.order > hcm_pkg::ORDER_W'(LEVEL)) begin
      if (up_data.op == hcm_pkg::OP_KEY2PT) begin
        digit                = up_data.key[2*LEVEL +: 2];
        co                   = hcm_pkg::KEY2PT_TBL[up_data.st][digit];
        data_next.uy[LEVEL]  = co[0];
        data_next.ux[LEVEL]  = co[1];
        data_next.st         = hcm_pkg::NEXT_TBL[up_data.st][digit];
      end else begin
        digit                       = {up_data.ux[LEVEL], up_data.uy[LEVEL]};
        co                          = hcm_pkg::PT2KEY_TBL[up_data.st][digit];
        data_next.key[2*LEVEL +: 2] = co;
        data_next.st                = hcm_pkg::NEXT_TBL[up_data.st][co];
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[src/hcm_out.sv]
`default_nettype none

module hcm_out (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  hcm_pkg::hcm_stage_t  up_data,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output hcm_pkg::hcm_rsp_t    rsp_word
);

  logic [hcm_pkg::COORD_W-1:0] shift;
  hcm_pkg::hcm_rsp_t           rsp_next;

  always_comb begin
    shift    = hcm_pkg::half_side(up_data.order);
    rsp_next = '0;
    if (up_data.op == hcm_pkg::OP_KEY2PT) begin
      rsp_next.x_out = $signed(up_data.ux - shift);
      rsp_next.y_out = $signed(up_data.uy - shift);
    end else if (up_data.oor) begin
      rsp_next.index_out    = '1;
      rsp_next.out_of_range = 1'b1;
    end else begin
      rsp_next.index_out = up_data.key;
    end
  end

  assign up_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (up_ready) begin
      rsp_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rsp_word <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[src/hilbert_curve_index_point_mapper.sv]
// Pipeline from an accepted req word to its rsp word: one input stage,
//   one cell per curve level, one output register.
// Throughput: one word per cycle unless rsp_ready stalls; every stage is a register with its own valid.
// Reset (rst, synchronous, active high) empties all stages and sets
//   curve_order to 8.
`default_nettype none

module hilbert_curve_index_point_mapper #(
  parameter int MAX_ORDER = hcm_pkg::MAX_ORDER_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  // config: curve order, written whenever cfg_we is high
  input  wire                         cfg_we,
  input  wire [hcm_pkg::ORDER_W-1:0]  cfg_wdata,
  // request channel
  input  wire                         req_valid,
  output logic                        req_ready,
  input  hcm_pkg::hcm_req_t           req_word,
  // response channel
  output logic                        rsp_valid,
  input  wire                         rsp_ready,
  output hcm_pkg::hcm_rsp_t           rsp_word
);

  // Curve order register.  Zero and values above MAX_ORDER are clamped
  // in the input stage, so the raw write is stored as given.
  logic [hcm_pkg::ORDER_W-1:0] curve_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= hcm_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      curve_order <= cfg_wdata;
    end
  end

  // Stage links.  Link 0 leaves the input stage; link g+1 leaves cell g.
  // Each word carries its own clamped order, so cells never look back at
  // the register.
  logic                  lnk_valid [MAX_ORDER+1];
  logic                  lnk_ready [MAX_ORDER+1];
  hcm_pkg::hcm_stage_t   lnk_data  [MAX_ORDER+1];

  // Input stage: clamp the order, do the open-range check on x and y,
  // and bias the coordinates to unsigned grid positions.
  hcm_prep #(
    .MAX_ORDER (MAX_ORDER)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_word    (req_word),
    .curve_order (curve_order),
    .dn_valid    (lnk_valid[0]),
    .dn_ready    (lnk_ready[0]),
    .dn_data     (lnk_data[0])
  );

  // Row of cells, most significant level first.  Cell g handles level
  // MAX_ORDER-1-g and passes the curve state to its neighbour; levels at
  // or above the word's order pass straight through with state 0, which
  // matches starting the walk at level order-1.
  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
    hcm_cell #(
      .LEVEL (MAX_ORDER - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (lnk_valid[g]),
      .up_ready (lnk_ready[g]),
      .up_data  (lnk_data[g]),
      .dn_valid (lnk_valid[g+1]),
      .dn_ready (lnk_ready[g+1]),
      .dn_data  (lnk_data[g+1])
    );
  end

  // Output register: remove the centring bias for index-to-point words,
  // and force the all-ones index on out-of-range points.
  hcm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (lnk_valid[MAX_ORDER]),
    .up_ready  (lnk_ready[MAX_ORDER]),
    .up_data   (lnk_data[MAX_ORDER]),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

endmodule

`default_nettype wire

[src/hcm_checker.sv]
`default_nettype none

module hcm_checker (
  input wire                clk,
  input wire                rst,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input hcm_pkg::hcm_rsp_t  rsp_word
);

  a_rst_empty : assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp word dropped while stalled");

  a_hold_word : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_word))
    else $error("rsp word changed while stalled");

  a_oor_word : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.out_of_range |->
      rsp_word.index_out == '1 && rsp_word.x_out == '0 && rsp_word.y_out == '0)
    else $error("out-of-range word malformed");

  a_point_word : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.x_out != '0 || rsp_word.y_out != '0) |->
      rsp_word.index_out == '0 && !rsp_word.out_of_range)
    else $error("point word carries an index");

endmodule

bind hilbert_curve_index_point_mapper hcm_checker u_hcm_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_word  (rsp_word)
);

`default_nettype wire

[bench/tb_hilbert_curve_index_point_mapper.sv]
`timescale 1ns / 1ps

module tb_hilbert_curve_index_point_mapper;

  // Deepest curve the block is built for; one cell per level plus
  // the input stage and the output register
  localparam int TOP_ORDER = 16;
  localparam int LATENCY = TOP_ORDER + 2;
  // Longest quiet stretch of a correct run is a random send gap plus a
  // random receive stall plus the pipe depth; allow many times that
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int PHASES = 10;

  typedef logic [1:0] lut_t [4][4];

  // Scoreboard: own copy of curve_order, predicts each word on acceptance
  class curve_scoreboard;
    hcm_pkg::hcm_rsp_t due_words[$];
    logic [hcm_pkg::ORDER_W-1:0] order;
    int errors;
    lut_t pt2key_lut;
    lut_t key2pt_lut;
    lut_t next_lut;

    function new();
      order = 5'd8;
      errors = 0;
      pt2key_lut = '{'{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd3, 2'd1, 2'd2},
                     '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd1, 2'd0}};
      key2pt_lut = '{'{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd3, 2'd1},
                     '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd3, 2'd2, 2'd0, 2'd1}};
      next_lut   = '{'{2'd1, 2'd0, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd1, 2'd3},
                     '{2'd3, 2'd2, 2'd2, 2'd0}, '{2'd2, 2'd3, 2'd3, 2'd1}};
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function hcm_pkg::hcm_rsp_t map_word(hcm_pkg::hcm_req_t rq);
      hcm_pkg::hcm_rsp_t r;
      int lvls;
      int lv;
      logic [1:0] st;
      logic [1:0] d;
      logic [1:0] co;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] ux;
      logic [31:0] uy;
      logic [31:0] key;
      longint shift;
      longint x;
      longint y;
      longint tmp;
      // order 0 runs as 1, anything past the top saturates
      if (order == 0) lvls = 1;
      else if (order > TOP_ORDER) lvls = TOP_ORDER;
      else lvls = int'(order);
      shift = longint'(1) << (lvls - 1);
      r = '0;
      st = 2'd0;
      if (rq.op == hcm_pkg::OP_KEY2PT) begin
        px = '0;
        py = '0;
        // digits above 2*order never enter the walk
        for (lv = lvls - 1; lv >= 0; lv--) begin
          d = rq.index_in[lv*2 +: 2];
          co = key2pt_lut[st][d];
          py[lv] = co[0];
          px[lv] = co[1];
          st = next_lut[st][d];
        end
        tmp = longint'(px) - shift;
        r.x_out = tmp[15:0];
        tmp = longint'(py) - shift;
        r.y_out = tmp[15:0];
      end else begin
        x = longint'($signed(rq.x_in));
        y = longint'($signed(rq.y_in));
        // open range: -shift itself is rejected as well as +shift
        if (x <= -shift || x >= shift || y <= -shift || y >= shift) begin
          r.index_out = '1;
          r.out_of_range = 1'b1;
        end else begin
          tmp = x + shift;
          ux = tmp[31:0];
          tmp = y + shift;
          uy = tmp[31:0];
          key = '0;
          for (lv = lvls - 1; lv >= 0; lv--) begin
            d = {ux[lv], uy[lv]};
            co = pt2key_lut[st][d];
            key[lv*2 +: 2] = co;
            st = next_lut[st][co];
          end
          r.index_out = key;
        end
      end
      return r;
    endfunction

    function void note_request(hcm_pkg::hcm_req_t rq);
      due_words.push_back(map_word(rq));
    endfunction

    function void check_response(hcm_pkg::hcm_rsp_t got);
      hcm_pkg::hcm_rsp_t want;
      if (due_words.size() == 0) begin
        $display("%0t: response with none due, got %h", $time, got);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.index_out !== want.index_out) begin
        $display("%0t: index_out expected %h got %h", $time, want.index_out, got.index_out);
        errors++;
      end
      if (got.x_out !== want.x_out) begin
        $display("%0t: x_out expected %0d got %0d", $time, want.x_out, got.x_out);
        errors++;
      end
      if (got.y_out !== want.y_out) begin
        $display("%0t: y_out expected %0d got %0d", $time, want.y_out, got.y_out);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $display("%0t: out_of_range expected %b got %b", $time, want.out_of_range,
                 got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [hcm_pkg::ORDER_W-1:0] cfg_wdata = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  hcm_pkg::hcm_req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hcm_pkg::hcm_rsp_t rsp_word;

  curve_scoreboard board;
  // calm phases: neither side idles
  bit calm = 1'b0;
  int idle_cycles;

  hilbert_curve_index_point_mapper #(
    .MAX_ORDER(TOP_ORDER)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_word(req_word),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_word(rsp_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Index-to-point word; the coordinate fields carry noise
  function automatic hcm_pkg::hcm_req_t key_word(logic [31:0] k);
    hcm_pkg::hcm_req_t w;
    w.op = hcm_pkg::OP_KEY2PT;
    w.index_in = k;
    w.x_in = $urandom;
    w.y_in = $urandom;
    return w;
  endfunction

  // Point-to-index word; the index field carries noise
  function automatic hcm_pkg::hcm_req_t pt_word(int x, int y);
    hcm_pkg::hcm_req_t w;
    w.op = hcm_pkg::OP_PT2KEY;
    w.index_in = $urandom;
    w.x_in = x;
    w.y_in = y;
    return w;
  endfunction

  // Offer one word after a random gap (none in calm phases); valid stays up until taken
  task automatic send_word(input hcm_pkg::hcm_req_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(w);
  endtask

  // Order changes only with the pipe empty: every word gives one result,
  // so nothing due means nothing in flight
  task automatic set_order(input logic [hcm_pkg::ORDER_W-1:0] v);
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.order = v;
  endtask

  // Receiver: random stall before each word (none in calm phases), then ready until one is taken
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      board.check_response(rsp_word);
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int n;
    int shift;
    int bnd;
    int inr;
    int mode;
    logic [hcm_pkg::ORDER_W-1:0] ord;
    hcm_pkg::hcm_req_t w;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset order of 8 (half side 128)
    send_word(key_word(32'h0000_0000));
    send_word(key_word(32'hFFFF_FFFF));
    send_word(key_word(32'h5555_5555));
    send_word(key_word(32'hAAAA_AAAA));
    send_word(pt_word(0, 0));
    send_word(pt_word(-128, 0));
    send_word(pt_word(-127, -127));
    send_word(pt_word(127, 127));
    send_word(pt_word(128, 0));
    send_word(pt_word(0, -128));
    send_word(pt_word(0, 128));
    send_word(pt_word(32'sh8000_0000, 32'sh7FFF_FFFF));
    send_word(pt_word(32'sh7FFF_FFFF, 32'sh8000_0000));

    // Smallest curve: only the centre point is inside
    set_order(5'd1);
    send_word(pt_word(0, 0));
    send_word(pt_word(-1, 0));
    send_word(pt_word(1, 0));
    send_word(pt_word(0, 1));
    send_word(key_word(32'h0000_0003));
    send_word(key_word(32'hFFFF_FFFF));

    // Largest curve: coordinates fill the 16-bit outputs
    set_order(5'd16);
    send_word(pt_word(-32767, -32767));
    send_word(pt_word(32767, 32767));
    send_word(pt_word(-32768, 0));
    send_word(pt_word(0, 32768));
    send_word(key_word(32'hFFFF_FFFF));
    send_word(key_word(32'h0000_0000));

    // Random phases, each at its own order; 0 and out-of-range orders
    // exercise the clamp
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: ord = 5'd0;
        1: ord = 5'd31;
        2: ord = 5'd17;
        3: ord = 5'd2;
        4: ord = 5'd16;
        5: ord = 5'd1;
        9: ord = 5'd8;
        default: ord = hcm_pkg::ORDER_W'($urandom_range(0, 31));
      endcase
      set_order(ord);
      calm = (p % 4 == 3);
      if (ord == 0) shift = 1;
      else if (ord > TOP_ORDER) shift = 1 << (TOP_ORDER - 1);
      else shift = 1 << (ord - 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          w = key_word($urandom);
        end else begin
          mode = $urandom_range(0, 9);
          inr = $urandom_range(0, 2 * shift - 2) - (shift - 1);
          case ($urandom_range(0, 3))
            0: bnd = -shift;
            1: bnd = -shift + 1;
            2: bnd = shift - 1;
            default: bnd = shift;
          endcase
          if (mode < 7) begin
            w = pt_word($urandom_range(0, 2 * shift - 2) - (shift - 1), inr);
          end else if (mode < 9) begin
            // one coordinate on or next to the edge
            if ($urandom_range(0, 1) == 0) w = pt_word(bnd, inr);
            else w = pt_word(inr, bnd);
          end else begin
            w = pt_word($urandom, $urandom);
          end
        end
        send_word(w);
      end
    end

    calm = 1'b0;
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // let any stray word show itself
    repeat (2 * LATENCY) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[hilbert_curve_index_point_mapper.f]
src/hcm_pkg.sv
src/hcm_prep.sv
src/hcm_cell.sv
src/hcm_out.sv
src/hilbert_curve_index_point_mapper.sv
src/hcm_checker.sv
bench/tb_hilbert_curve_index_point_mapper.sv
